// ===== hdl/avr_pkg.sv =====
// Shared constants, types and the sine table for the axis-angle vector rotator.
// No dependencies; every other file of the block but avr_ram imports this package.
package avr_pkg;

    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int SINE_W = 17;
    localparam int TRIG_W = SINE_W + 1;

    localparam int VEC_W  = 32;
    localparam int AXIS_W = 16;
    localparam int ANG_W  = 16;
    localparam int PHASE_W = ANG_W - 2;
    localparam int QP_W   = PHASE_W + 1;
    localparam int ONE_Q16 = 65536;
    localparam int QUARTER_TURN = 16384;

    localparam int AXIS_SH   = 14;
    localparam int RND_SH    = 16;
    localparam int PUV_W     = VEC_W + AXIS_W;
    localparam int DOT_SUM_W = PUV_W + 2;
    localparam int DOT_W     = DOT_SUM_W - AXIS_SH;
    localparam int CR_SUM_W  = PUV_W + 1;
    localparam int CR_W      = CR_SUM_W - AXIS_SH;
    localparam int OMC_W     = TRIG_W + 1;
    localparam int VALP_W    = DOT_W + OMC_W;
    localparam int VAL_W     = VALP_W - RND_SH;
    localparam int VU_W      = VAL_W + AXIS_W + 2;
    localparam int CV_W      = TRIG_W + VEC_W;
    localparam int SC_W      = TRIG_W + CR_W;
    localparam int CS_W      = SC_W + 1;
    localparam int ACC_W     = VU_W + 1;
    localparam int SH_W      = ACC_W - RND_SH;

    localparam int LANES = 3;

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_trig;

    typedef logic [SINE_W-1:0] t_sine_rom [SINE_TABLE_ENTRIES+1];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    // Q1.16 quarter-wave sine, Taylor series evaluated in Q30
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
                if ((k & 1) != 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            rom[i] = SINE_W'((unsigned'(sum) + 64'd8192) >> 14);
        end
        rom[SINE_TABLE_ENTRIES] = SINE_W'(ONE_Q16);
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== hdl/avr_in_if.sv =====
// Input channel of the rotator: vector, axis and angle word with valid/ready.
// Depends on avr_pkg for field widths.
interface avr_in_if;
    import avr_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [ANG_W-1:0]         turn_angle;

    modport source (
        output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
        input  ready
    );
    modport sink (
        input  valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle,
        output ready
    );
endinterface

// ===== hdl/avr_out_if.sv =====
// Output channel of the rotator: rotated vector word with valid/ready.
// Depends on avr_pkg for field widths.
interface avr_out_if;
    import avr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;

    modport source (
        output valid, rot_x, rot_y, rot_z,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z,
        output ready
    );
endinterface

// ===== hdl/avr_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module avr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end
endmodule

// ===== hdl/avr_sincos.sv =====
// Sine/cosine unit: loads the quarter-wave table into RAM after reset, then
// looks up sine and cosine of an angle from registered table reads. Uses avr_pkg, avr_ram.
module avr_sincos (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [avr_pkg::ANG_W-1:0]  i_angle,
    output logic                       o_fill_done,
    output avr_pkg::t_trig             o_trig
);
    import avr_pkg::*;

    logic [IDX_W-1:0]  r_fill_idx;
    logic              r_fill_done;
    logic [ANG_W-1:0]  cos_angle;
    logic [IDX_W-1:0]  sin_addr;
    logic [IDX_W-1:0]  cos_addr;
    logic [SINE_W-1:0] sin_mag;
    logic [SINE_W-1:0] cos_mag;
    logic              r_sin_neg;
    logic              r_cos_neg;

    function automatic logic [IDX_W-1:0] quarter_index(input logic [ANG_W-1:0] ang);
        logic [QP_W-1:0]       pp;
        logic [QP_W+IDX_W-1:0] prod;
        pp = ang[PHASE_W] ? (QP_W'(QUARTER_TURN) - QP_W'(ang[PHASE_W-1:0]))
                          : QP_W'(ang[PHASE_W-1:0]);
        prod = (QP_W+IDX_W)'(pp) * (QP_W+IDX_W)'(SINE_TABLE_ENTRIES);
        return prod[PHASE_W +: IDX_W];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_idx  <= '0;
            r_fill_done <= 1'b0;
        end else if (!r_fill_done) begin
            if (r_fill_idx == IDX_W'(SINE_TABLE_ENTRIES)) begin
                r_fill_done <= 1'b1;
            end else begin
                r_fill_idx <= r_fill_idx + 1'b1;
            end
        end
    end

    assign cos_angle = i_angle + ANG_W'(QUARTER_TURN);
    assign sin_addr  = quarter_index(i_angle);
    assign cos_addr  = quarter_index(cos_angle);

    avr_ram #(
        .WIDTH (SINE_W),
        .DEPTH (SINE_TABLE_ENTRIES + 1)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (!r_fill_done),
        .i_wr_addr   (r_fill_idx),
        .i_wr_data   (SINE_ROM[r_fill_idx]),
        .i_rd_en     (i_rd_en),
        .i_rd_addr_a (sin_addr),
        .i_rd_addr_b (cos_addr),
        .o_rd_data_a (sin_mag),
        .o_rd_data_b (cos_mag)
    );

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sin_neg <= i_angle[ANG_W-1];
            r_cos_neg <= cos_angle[ANG_W-1];
        end
    end

    always_comb begin
        o_trig.sin_v = r_sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        o_trig.cos_v = r_cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    end

    assign o_fill_done = r_fill_done;
endmodule

// ===== hdl/avr_rotate_pipe.sv =====
// Rodrigues datapath: products, dot/cross, trig scaling, axis term, accumulate, round and
// saturate, one register stage each, with per-stage valid and stall. Uses avr_pkg.
module avr_rotate_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    output logic                         o_load_en,
    input  logic signed [avr_pkg::VEC_W-1:0]  i_vec  [avr_pkg::LANES],
    input  logic signed [avr_pkg::AXIS_W-1:0] i_axis [avr_pkg::LANES],
    input  avr_pkg::t_trig               i_trig,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [avr_pkg::VEC_W-1:0]  o_rot  [avr_pkg::LANES]
);
    import avr_pkg::*;

    logic en1, en2, en3, en4, en5, en6;
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r_out_vld;

    logic signed [PUV_W-1:0]  r1_pd [LANES];
    logic signed [PUV_W-1:0]  r1_pa [LANES];
    logic signed [PUV_W-1:0]  r1_pb [LANES];
    t_vec                     r1_v  [LANES];
    t_axis                    r1_u  [LANES];

    logic signed [DOT_SUM_W-1:0] dot_sum;
    logic signed [CR_SUM_W-1:0]  cr_sum [LANES];
    logic signed [DOT_W-1:0]     r2_dot;
    logic signed [CR_W-1:0]      r2_cr  [LANES];
    logic signed [TRIG_W-1:0]    r2_sin;
    logic signed [TRIG_W-1:0]    r2_cos;
    t_vec                        r2_v   [LANES];
    t_axis                       r2_u   [LANES];

    logic signed [OMC_W-1:0]  omc;
    logic signed [VALP_W-1:0] r3_valp;
    logic signed [CV_W-1:0]   r3_cv [LANES];
    logic signed [SC_W-1:0]   r3_sc [LANES];
    t_axis                    r3_u  [LANES];

    logic signed [VAL_W-1:0]  val16;
    logic signed [VU_W-1:0]   r4_vu [LANES];
    logic signed [CS_W-1:0]   r4_cs [LANES];

    logic signed [ACC_W-1:0]  r5_acc [LANES];

    logic signed [ACC_W-1:0]  rnd [LANES];
    logic signed [SH_W-1:0]   sh  [LANES];
    t_vec                     sat [LANES];
    t_vec                     r_out [LANES];

    assign en6 = !r_out_vld || i_ready;
    assign en5 = !r5_vld || en6;
    assign en4 = !r4_vld || en5;
    assign en3 = !r3_vld || en4;
    assign en2 = !r2_vld || en3;
    assign en1 = !r1_vld || en2;
    assign o_load_en = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en1) r1_vld    <= i_take;
            if (en2) r2_vld    <= r1_vld;
            if (en3) r3_vld    <= r2_vld;
            if (en4) r4_vld    <= r3_vld;
            if (en5) r5_vld    <= r4_vld;
            if (en6) r_out_vld <= r5_vld;
        end
    end

    // stage 1: the nine axis-by-vector products
    for (genvar j = 0; j < LANES; j++) begin : g_prod
        localparam int J1 = (j + 1) % LANES;
        localparam int J2 = (j + 2) % LANES;
        always_ff @(posedge i_clk) begin
            if (en1) begin
                r1_pd[j] <= PUV_W'(i_axis[j])  * PUV_W'(i_vec[j]);
                r1_pa[j] <= PUV_W'(i_axis[J1]) * PUV_W'(i_vec[J2]);
                r1_pb[j] <= PUV_W'(i_axis[J2]) * PUV_W'(i_vec[J1]);
                r1_v[j]  <= i_vec[j];
                r1_u[j]  <= i_axis[j];
            end
        end
    end

    // stage 2: dot and cross products back to Q16, signed sine/cosine
    always_comb begin
        dot_sum = DOT_SUM_W'(r1_pd[0]) + DOT_SUM_W'(r1_pd[1]) + DOT_SUM_W'(r1_pd[2]);
        for (int j = 0; j < LANES; j++) begin
            cr_sum[j] = CR_SUM_W'(r1_pa[j]) - CR_SUM_W'(r1_pb[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_dot <= $signed(dot_sum[DOT_SUM_W-1:AXIS_SH]);
            r2_sin <= i_trig.sin_v;
            r2_cos <= i_trig.cos_v;
            for (int j = 0; j < LANES; j++) begin
                r2_cr[j] <= $signed(cr_sum[j][CR_SUM_W-1:AXIS_SH]);
                r2_v[j]  <= r1_v[j];
                r2_u[j]  <= r1_u[j];
            end
        end
    end

    // stage 3: trig scaling
    assign omc = OMC_W'(ONE_Q16) - OMC_W'(r2_cos);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_valp <= VALP_W'(r2_dot) * VALP_W'(omc);
            for (int j = 0; j < LANES; j++) begin
                r3_cv[j] <= CV_W'(r2_cos) * CV_W'(r2_v[j]);
                r3_sc[j] <= SC_W'(r2_sin) * SC_W'(r2_cr[j]);
                r3_u[j]  <= r2_u[j];
            end
        end
    end

    // stage 4: axis term and partial sum
    assign val16 = $signed(r3_valp[VALP_W-1:RND_SH]);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int j = 0; j < LANES; j++) begin
                r4_vu[j] <= (VU_W'(val16) * VU_W'(r3_u[j])) <<< 2;
                r4_cs[j] <= CS_W'(r3_cv[j]) + CS_W'(r3_sc[j]);
            end
        end
    end

    // stage 5: Q32 accumulator
    always_ff @(posedge i_clk) begin
        if (en5) begin
            for (int j = 0; j < LANES; j++) begin
                r5_acc[j] <= ACC_W'(r4_cs[j]) + ACC_W'(r4_vu[j]);
            end
        end
    end

    // output: round half up, floor shift, saturate
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            rnd[j] = r5_acc[j] + ACC_W'(32768);
            sh[j]  = $signed(rnd[j][ACC_W-1:RND_SH]);
            if (sh[j][SH_W-1:VEC_W-1] == '0 || sh[j][SH_W-1:VEC_W-1] == '1) begin
                sat[j] = sh[j][VEC_W-1:0];
            end else if (!sh[j][SH_W-1]) begin
                sat[j] = $signed({1'b0, {(VEC_W-1){1'b1}}});
            end else begin
                sat[j] = $signed({1'b1, {(VEC_W-1){1'b0}}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            for (int j = 0; j < LANES; j++) begin
                r_out[j] <= sat[j];
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_rot   = r_out;
endmodule

// ===== hdl/axis_angle_vector_rotate.sv =====
// Axis-angle (Rodrigues) rotation of a Q16.16 vector about a Q2.14 axis by a
// binary angle. After reset the block loads its sine table, SINE_TABLE_ENTRIES + 1
// entries (1025 at the default table size), into RAM and holds ready low; after
// that it takes one word per cycle while the output is not stalled. The accepting
// edge loads the product and table-read stage, and the dot/cross, trig scaling,
// axis term, accumulator and rounded output registers follow in that order;
// stalls on the output back up through the stages without losing or repeating
// words. The axis is used as given, not normalized, and results saturate to the
// 32-bit range. Uses avr_pkg, avr_in_if, avr_out_if, avr_sincos and avr_rotate_pipe.
module axis_angle_vector_rotate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    avr_in_if.sink      i_in,
    avr_out_if.source   o_out
);
    import avr_pkg::*;

    logic  fill_done;
    logic  load_en;
    logic  take;
    t_trig trig;
    t_vec  vec  [LANES];
    t_axis axis [LANES];
    t_vec  rot  [LANES];

    assign vec[0]  = i_in.vec_x;
    assign vec[1]  = i_in.vec_y;
    assign vec[2]  = i_in.vec_z;
    assign axis[0] = i_in.axis_x;
    assign axis[1] = i_in.axis_y;
    assign axis[2] = i_in.axis_z;

    assign i_in.ready = fill_done && load_en;
    assign take       = i_in.valid && i_in.ready;

    avr_sincos u_sincos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (load_en),
        .i_angle     (i_in.turn_angle),
        .o_fill_done (fill_done),
        .o_trig      (trig)
    );

    avr_rotate_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .o_load_en (load_en),
        .i_vec     (vec),
        .i_axis    (axis),
        .i_trig    (trig),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_rot     (rot)
    );

    assign o_out.rot_x = rot[0];
    assign o_out.rot_y = rot[1];
    assign o_out.rot_z = rot[2];

`ifndef SYNTHESIS
    a_fill_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_done |=> fill_done)
        else $error("table load flag dropped after completion");

    a_no_out_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fill_done |-> !o_out.valid)
        else $error("output word presented while table is loading");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_done && !o_out.valid |-> i_in.ready)
        else $error("input stalled while output register is empty");
`endif
endmodule
